### src/expo_curve_blend_assert.svh
// Assertion helpers for the expo curve blend block
`ifndef EXPO_CURVE_BLEND_ASSERT_SVH
`define EXPO_CURVE_BLEND_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define ECB_ASSERT_HOLDS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("expo_curve_blend: invariant violated");

// ante implies cons in the same cycle
`define ECB_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("expo_curve_blend: implication violated");

`endif

### src/ecb_pkg.sv
package ecb_pkg;

   localparam int unsigned CURVE_POINTS = 15;
   localparam int unsigned MAG_W       = 9;
   localparam int unsigned PCT_W       = 7;
   localparam int unsigned SUM_W       = 15;
   localparam int unsigned PROD_W      = 31;

   localparam logic [MAG_W-1:0] FULL_SCALE = 9'd256;
   localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;

   // x / 100 == (x * 41944) >> 22 for x <= 25600
   localparam logic [15:0] DIV_RECIP = 16'd41944;
   localparam int unsigned DIV_SHIFT = 22;

   localparam logic [MAG_W-1:0] TAB_POS [CURVE_POINTS] = '{
      9'd0, 9'd1, 9'd2, 9'd4, 9'd8, 9'd14, 9'd21, 9'd32,
      9'd46, 9'd63, 9'd83, 9'd108, 9'd137, 9'd171, 9'd210};

   localparam logic [MAG_W-1:0] TAB_NEG [CURVE_POINTS] = '{
      9'd101, 9'd128, 9'd147, 9'd161, 9'd174, 9'd185, 9'd194, 9'd203,
      9'd211, 9'd219, 9'd226, 9'd232, 9'd239, 9'd245, 9'd251};

   // curve point k, with implicit end points 0 and full scale
   function automatic logic [MAG_W-1:0] point_at(input logic use_neg, input logic [4:0] k);
      logic [3:0] idx;
      idx = k[3:0] - 4'd1;
      if (k == 5'd0)
         return '0;
      else if (k > 5'(CURVE_POINTS))
         return FULL_SCALE;
      else if (use_neg)
         return TAB_NEG[idx];
      else
         return TAB_POS[idx];
   endfunction

endpackage

### src/expo_curve_blend.sv
// Five register stages: table lookup, interpolation, blend, reciprocal multiply, sign restore.
// Each request passes through the stage registers in order, from the request port to the response port.
// Throughput is one request per cycle while rsp_stall stays low.
// Each stage advances when it is empty or the next stage advances.
// Synchronous active-high reset clears the stage valid bits and sets expo_percent to 0.
`include "expo_curve_blend_assert.svh"

module expo_curve_blend (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [9:0] req_sample_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [9:0] rsp_sample_out,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_expo_percent
);
   import ecb_pkg::*;

   logic [7:0] expo_ff;

   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                en1, en2, en3, en4, en5;

   logic                neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [MAG_W-1:0]    m1_ff, m2_ff;
   logic [MAG_W-1:0]    lo1_ff, hi1_ff;
   logic [PCT_W-1:0]    w1_ff, w2_ff;
   logic [MAG_W-1:0]    curve2_ff;
   logic [SUM_W-1:0]    sum3_ff;
   logic [PROD_W-1:0]   prod4_ff;
   logic [9:0]          out5_ff;

   logic                neg1_in;
   logic [9:0]          mag_raw;
   logic [MAG_W-1:0]    m1_in;
   logic [4:0]          seg;
   logic [7:0]          e_abs;
   logic [PCT_W-1:0]    w1_in;
   logic                use_neg;
   logic [MAG_W-1:0]    lo1_in, hi1_in;
   logic [3:0]          frac;
   logic [13:0]         interp;
   logic [MAG_W-1:0]    curve2_in;
   logic [SUM_W-1:0]    sum3_in;
   logic [PROD_W-1:0]   prod4_in;
   logic [MAG_W-1:0]    quot;
   logic [9:0]          out5_in;

   // stage enables, back from the output
   assign en5 = !v5_ff || !rsp_stall;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign csr_ready = 1'b1;
   assign rsp_valid = v5_ff;
   assign rsp_sample_out = out5_ff;

   // stage 1: magnitude, segment, table points, weight
   always_comb begin
      neg1_in = req_sample_in[9];
      mag_raw = neg1_in ? (~req_sample_in + 10'd1) : req_sample_in;
      m1_in   = (mag_raw > 10'(FULL_SCALE)) ? FULL_SCALE : mag_raw[MAG_W-1:0];
      seg     = m1_in[8:4];
      e_abs   = expo_ff[7] ? (~expo_ff + 8'd1) : expo_ff;
      w1_in   = (e_abs > 8'(PCT_FULL)) ? PCT_FULL : e_abs[PCT_W-1:0];
      use_neg = expo_ff[7];
      lo1_in  = point_at(use_neg, seg);
      hi1_in  = point_at(use_neg, seg + 5'd1);
   end

   // stage 2: linear interpolation
   always_comb begin
      frac      = m1_ff[3:0];
      interp    = 14'(lo1_ff) * 14'(5'd16 - {1'b0, frac}) + 14'(hi1_ff) * 14'(frac);
      curve2_in = interp[12:4];
   end

   // stage 3: percentage blend
   assign sum3_in = SUM_W'(m2_ff) * SUM_W'(PCT_FULL - w2_ff)
                  + SUM_W'(curve2_ff) * SUM_W'(w2_ff);

   // stage 4: divide by 100 via reciprocal
   assign prod4_in = PROD_W'(sum3_ff) * PROD_W'(DIV_RECIP);

   // stage 5: sign restore
   always_comb begin
      quot    = prod4_ff[DIV_SHIFT +: MAG_W];
      out5_in = neg4_ff ? (~{1'b0, quot} + 10'd1) : {1'b0, quot};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expo_ff <= '0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         v5_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            expo_ff <= csr_expo_percent;
         end
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         neg1_ff <= neg1_in;
         m1_ff   <= m1_in;
         lo1_ff  <= lo1_in;
         hi1_ff  <= hi1_in;
         w1_ff   <= w1_in;
      end
      if (en2) begin
         neg2_ff   <= neg1_ff;
         m2_ff     <= m1_ff;
         w2_ff     <= w1_ff;
         curve2_ff <= curve2_in;
      end
      if (en3) begin
         neg3_ff <= neg2_ff;
         sum3_ff <= sum3_in;
      end
      if (en4) begin
         neg4_ff  <= neg3_ff;
         prod4_ff <= prod4_in;
      end
      if (en5) begin
         out5_ff <= out5_in;
      end
   end

   `ECB_ASSERT_IMPLIES(a_curve_bound, v2_ff, curve2_ff <= FULL_SCALE)
   `ECB_ASSERT_IMPLIES(a_sum_bound, v3_ff, sum3_ff <= 15'd25600)
   `ECB_ASSERT_IMPLIES(a_full_backpressure, v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall, req_stall)

endmodule
